[rtl/core/decimal_integer_parser_assert.svh]
// ----------------------------------------------------------------------------
// Decimal integer parser: assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_PARSER_ASSERT_SVH
`define DECIMAL_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication
`define DIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal integer parser package
// Character codes and the per-string parse state type.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned PROD_W  = VALUE_W + 4;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               neg;
        logic               failed;
        logic               at_first;
        logic               seen;
    } t_parse_state;

endpackage

[rtl/core/decimal_integer_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal integer parser
// Streams ASCII characters of one decimal number and returns its 64-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one character per transaction
//   with i_char_valid (character present) and i_last (end of string).
//   Output channel (o_valid / i_stall) carries one transaction per string,
//   o_value and o_ok, issued for the transaction marked last.
//   i_cfg_we writes i_cfg_wdata into signed mode (reset 1); write only while
//   no string is in flight.
//   Throughput: one character per cycle, except that a last character waits
//   while the receiver stalls. The accumulator multiply-by-ten, add and overflow
//   check are combinational, through a shift-add. A last transaction is held
//   in the input register, then registered into the output register.
//   When the receiver stalls, the result register holds; characters without
//   last keep flowing, and the next last character waits in the input register.
//   Reset clears the string state and both valid flags, and sets signed mode.
// ----------------------------------------------------------------------------
`include "decimal_integer_parser_assert.svh"

module decimal_integer_parser
    import dip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_character,
    input  logic                i_char_valid,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VALUE_W-1:0]  o_value,
    output logic                o_ok
);

    logic               r_signed_mode;
    logic               r_s1_vld;
    logic [7:0]         r_s1_char;
    logic               r_s1_char_valid;
    logic               r_s1_last;
    t_parse_state       r_state;
    t_parse_state       n_state;
    logic               r_out_vld;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ok;
    logic [VALUE_W-1:0] n_out_value;
    logic               n_out_ok;

    logic               out_ready;
    logic               s1_fire;
    logic               in_accept;
    logic               dec_char;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  prod;
    t_parse_state       c_state;
    logic               good;
    logic               last_fire;
    logic               fail_out;
    logic               state_clear;
    logic               first_clean;

    assign out_ready = !r_out_vld || !i_stall;
    assign s1_fire   = r_s1_vld && (!r_s1_last || out_ready);
    assign o_stall   = r_s1_vld && !s1_fire;
    assign in_accept = i_valid && !o_stall;

    assign dec_char = (r_s1_char >= CHAR_ZERO) && (r_s1_char <= CHAR_NINE);
    assign digit    = 4'(r_s1_char - CHAR_ZERO);
    assign prod     = ({4'b0, r_state.acc} << 3) + ({4'b0, r_state.acc} << 1)
                    + {{(PROD_W-4){1'b0}}, digit};

    always_comb begin
        c_state = r_state;
        if (r_s1_char_valid) begin
            c_state.at_first = 1'b0;
            if (!r_state.failed) begin
                if (r_state.at_first && r_signed_mode && (r_s1_char == CHAR_MINUS)) begin
                    c_state.neg = 1'b1;
                end else if (r_state.at_first && r_signed_mode
                             && (r_s1_char == CHAR_PLUS)) begin
                    c_state.failed = 1'b1;
                end else if (!dec_char) begin
                    c_state.failed = 1'b1;
                end else if (prod[PROD_W-1:VALUE_W] != 4'b0) begin
                    c_state.failed = 1'b1;
                end else begin
                    c_state.acc  = prod[VALUE_W-1:0];
                    c_state.seen = 1'b1;
                end
            end
        end
    end

    always_comb begin
        good        = !c_state.failed && c_state.seen;
        n_out_value = c_state.acc;
        if (r_signed_mode) begin
            if (c_state.neg) begin
                if (c_state.acc[VALUE_W-1] && (c_state.acc[VALUE_W-2:0] != '0)) begin
                    good = 1'b0;
                end
                n_out_value = '0 - c_state.acc;
            end else if (c_state.acc[VALUE_W-1]) begin
                good = 1'b0;
            end
        end else if (c_state.neg) begin
            good = 1'b0;
        end
        if (!good) begin
            n_out_value = '0;
        end
        n_out_ok = good;
    end

    always_comb begin
        n_state = r_state;
        if (s1_fire) begin
            n_state = c_state;
            if (r_s1_last) begin
                n_state = '{acc: '0, neg: 1'b0, failed: 1'b0, at_first: 1'b1, seen: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_state       <= '{acc: '0, neg: 1'b0, failed: 1'b0, at_first: 1'b1, seen: 1'b0};
        end else begin
            if (i_cfg_we) begin
                r_signed_mode <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (out_ready) begin
                r_out_vld <= s1_fire && r_s1_last;
            end
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char       <= i_character;
            r_s1_char_valid <= i_char_valid;
            r_s1_last       <= i_last;
        end
        if (out_ready && s1_fire && r_s1_last) begin
            r_out_value <= n_out_value;
            r_out_ok    <= n_out_ok;
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_value;
    assign o_ok    = r_out_ok;

    assign last_fire   = s1_fire && r_s1_last;
    assign fail_out    = r_out_vld && !r_out_ok;
    assign state_clear = r_state.at_first && !r_state.failed && (r_state.acc == '0);
    assign first_clean = !r_state.seen && !r_state.neg && !r_state.failed;

    `DIP_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, fail_out, r_out_value == '0, "nonzero on fail")
    `DIP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, last_fire, state_clear, "state not cleared")
    `DIP_ASSERT_NEXT(a_last_shows, i_clk, i_rst_n, last_fire, r_out_vld, "result missing")
    `DIP_ASSERT_NOW(a_first_clean, i_clk, i_rst_n, r_state.at_first, first_clean, "dirty state")

endmodule
